// File: rtl/sprc_pkg.sv
// ----------------------------------------------------------------------------
// sprc_pkg
// shared constants and types for the sprite list compactor
// ----------------------------------------------------------------------------
package sprc_pkg;

    localparam int SLOT_COUNT     = 256;
    localparam int WORDS_PER_SLOT = 8;

    localparam int WORD_W  = 16;
    localparam int INDEX_W = 11;
    localparam int SLOTS_W = 9;

    localparam int POS_W  = (WORDS_PER_SLOT > 1) ? $clog2(WORDS_PER_SLOT) : 1;
    localparam int SRC_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int FILL_W = $clog2(SLOT_COUNT + 1);
    localparam int IDX_CALC_W = FILL_W + POS_W + 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_CLEAR = 1'b1
    } result_kind_t;

    typedef struct packed {
        result_kind_t        kind;
        logic [INDEX_W-1:0]  index;
        logic [WORD_W-1:0]   data;
        logic [SLOTS_W-1:0]  first_slot;
        logic [SLOTS_W-1:0]  slot_count;
        logic                last;
    } sprc_result_t;

    typedef struct packed {
        logic [1:0]   num;
        sprc_result_t first;
        sprc_result_t second;
    } sprc_push_t;

endpackage

// File: rtl/sprc_engine.sv
// ----------------------------------------------------------------------------
// sprc_engine
// slot tracking and result generation, one source word per cycle while accept is high
// ----------------------------------------------------------------------------
module sprc_engine
    import sprc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [WORD_W-1:0] word_data,
    output sprc_push_t        push
);

    logic [POS_W-1:0]  word_pos_reg, word_pos_next;
    logic [SRC_W-1:0]  source_slot_reg, source_slot_next;
    logic [FILL_W-1:0] filled_reg, filled_next;
    logic              active_reg, active_next;

    logic                  active_now;
    logic                  slot_end;
    logic                  list_end;
    logic [FILL_W-1:0]     filled_after;
    logic [FILL_W-1:0]     clear_count;
    logic [IDX_CALC_W-1:0] idx_full;
    sprc_result_t          wr_res;
    sprc_result_t          clr_res;

    always_comb
    begin
        active_now = (word_pos_reg == '0)
                   ? (word_data[15] && (word_data[7:0] != 8'h00))
                   : active_reg;
        slot_end = (word_pos_reg == POS_W'(WORDS_PER_SLOT - 1));
        list_end = slot_end && (source_slot_reg == SRC_W'(SLOT_COUNT - 1));

        if (slot_end && active_now && (filled_reg < FILL_W'(SLOT_COUNT)))
            filled_after = filled_reg + FILL_W'(1);
        else
            filled_after = filled_reg;
        clear_count = FILL_W'(SLOT_COUNT) - filled_after;

        idx_full = IDX_CALC_W'(filled_reg) * IDX_CALC_W'(WORDS_PER_SLOT)
                 + IDX_CALC_W'(word_pos_reg);

        wr_res.kind       = KIND_WRITE;
        wr_res.index      = INDEX_W'(idx_full);
        wr_res.data       = word_data;
        wr_res.first_slot = '0;
        wr_res.slot_count = '0;
        wr_res.last       = !list_end;

        clr_res.kind       = KIND_CLEAR;
        clr_res.index      = '0;
        clr_res.data       = '0;
        clr_res.first_slot = SLOTS_W'(filled_after);
        clr_res.slot_count = SLOTS_W'(clear_count);
        clr_res.last       = 1'b1;

        push.first  = active_now ? wr_res : clr_res;
        push.second = clr_res;
        if (!accept)
            push.num = 2'd0;
        else
            push.num = 2'({1'b0, active_now} + {1'b0, list_end});

        word_pos_next    = word_pos_reg;
        source_slot_next = source_slot_reg;
        filled_next      = filled_reg;
        active_next      = active_reg;
        if (accept)
        begin
            if (list_end)
            begin
                word_pos_next    = '0;
                source_slot_next = '0;
                filled_next      = '0;
                active_next      = 1'b0;
            end
            else if (slot_end)
            begin
                word_pos_next    = '0;
                source_slot_next = source_slot_reg + SRC_W'(1);
                filled_next      = filled_after;
                active_next      = 1'b0;
            end
            else
            begin
                word_pos_next = word_pos_reg + POS_W'(1);
                active_next   = active_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_pos_reg    <= '0;
            source_slot_reg <= '0;
            filled_reg      <= '0;
            active_reg      <= 1'b0;
        end
        else
        begin
            word_pos_reg    <= word_pos_next;
            source_slot_reg <= source_slot_next;
            filled_reg      <= filled_next;
            active_reg      <= active_next;
        end
    end

endmodule

// File: rtl/sprc_out_queue.sv
// ----------------------------------------------------------------------------
// sprc_out_queue
// small result queue taking up to two results per cycle, one out per cycle while out_ready is high
// ----------------------------------------------------------------------------
module sprc_out_queue
    import sprc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  sprc_push_t   push,
    output logic         space_ok,
    output logic         out_valid,
    input  logic         out_ready,
    output sprc_result_t head
);

    sprc_result_t      entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              pop;

    always_comb
    begin
        space_ok  = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));
        out_valid = (count_reg != '0);
        head      = entry_reg[rd_ptr_reg];
        pop       = out_valid && out_ready;

        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.num);
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push.num) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
            entry_reg[wr_ptr_reg] <= push.first;
        if (push.num == 2'd2)
            entry_reg[wr_ptr_reg + QPTR_W'(1)] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/sprite_list_compactor.sv
// ----------------------------------------------------------------------------
// sprite_list_compactor
// compacts active sprite slots of a source list into a destination table
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_ready  word_data
//   out      output     out_valid/out_ready  result_kind, write_index,
//                                            write_data, clear_first_slot,
//                                            clear_slot_count, run_last
//
// one source word is taken per cycle while in_ready is high; results are
// registered in the queue. the last word of a list can give two results,
// held in a four-entry queue, so input is taken while two or fewer
// results wait. reset clears the slot counters and empties the queue.
// a stalled output only stops input once the queue is nearly full.
// ----------------------------------------------------------------------------
module sprite_list_compactor
    import sprc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [WORD_W-1:0]  word_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               result_kind,
    output logic [INDEX_W-1:0] write_index,
    output logic [WORD_W-1:0]  write_data,
    output logic [SLOTS_W-1:0] clear_first_slot,
    output logic [SLOTS_W-1:0] clear_slot_count,
    output logic               run_last
);

    sprc_push_t   push;
    sprc_result_t head;
    logic         space_ok;
    logic         accept;

    assign in_ready = space_ok;
    assign accept   = in_valid && space_ok;

    sprc_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .word_data (word_data),
        .push      (push)
    );

    sprc_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (space_ok),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign result_kind      = head.kind;
    assign write_index      = head.index;
    assign write_data       = head.data;
    assign clear_first_slot = head.first_slot;
    assign clear_slot_count = head.slot_count;
    assign run_last         = head.last;

endmodule
